// File: rtl/core/kct_pkg.sv
// Package for the constant-velocity Kalman tracker: micro-op encoding,
// operand address map, program ROM and shared fixed-point helpers.
// No dependencies.
package kct_pkg;

  typedef logic [6:0] addr_t;

  typedef enum logic [2:0] {
    K_NOP,
    K_ADD,
    K_SUB,
    K_MUL,
    K_MUL16,
    K_DIV,
    K_CHKZ
  } kind_e;

  typedef struct packed {
    kind_e kind;
    addr_t src_a;
    addr_t src_b;
    addr_t dst;
    logic  last;
  } uop_t;

  typedef struct packed {
    logic  start;
    kind_e kind;
  } alu_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_WAIT,
    ST_OUT
  } seq_state_e;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV,
    AS_FIN,
    AS_DONE
  } alu_state_e;

  localparam logic CFG_PROCESS_NOISE     = 1'b0;
  localparam logic CFG_MEASUREMENT_NOISE = 1'b1;
  localparam logic OP_PREDICT            = 1'b0;

  localparam logic [31:0] NOISE_RESET = 32'h0001_0000;

  // Scratch memory map (0..63)
  localparam int A_P   = 0;
  localparam int A_T   = 16;
  localparam int A_T2  = 17;
  localparam int A_S00 = 18;
  localparam int A_S01 = 19;
  localparam int A_S10 = 20;
  localparam int A_S11 = 21;
  localparam int A_DET = 22;
  localparam int A_INV = 23;
  localparam int A_K   = 27;
  localparam int A_IN0 = 35;
  localparam int A_IN1 = 36;
  localparam int A_NP  = 37;

  // Register operands (bit 6 set)
  localparam int A_EST0 = 64;
  localparam int A_EST1 = 65;
  localparam int A_EST2 = 66;
  localparam int A_EST3 = 67;
  localparam int A_MX   = 68;
  localparam int A_MY   = 69;
  localparam int A_DT16 = 70;
  localparam int A_DT   = 71;
  localparam int A_Q    = 72;
  localparam int A_R    = 73;
  localparam int A_ZERO = 74;
  localparam int A_ONE  = 75;

  localparam int PRED_BASE = 0;
  localparam int INIT_BASE = 40;
  localparam int UPD_BASE  = 60;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  function automatic uop_t mk(input kind_e kind, input int a, input int b, input int d,
                              input logic last);
    uop_t u;
    u.kind  = kind;
    u.src_a = 7'(a);
    u.src_b = 7'(b);
    u.dst   = 7'(d);
    u.last  = last;
    return u;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v[63:31] == {33{v[63]}}) r = v[31:0];
    else r = v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return r;
  endfunction

  // Micro-program: predict, first update, regular update.
  function automatic uop_t prog_rom(input logic [7:0] pc);
    int   n, k, g, i, j, m;
    uop_t u;
    n = int'(pc);
    u = mk(K_NOP, A_ZERO, A_ZERO, A_ZERO, 1'b1);
    if (n < INIT_BASE) begin
      if (n < 4) begin
        i = n >> 1;
        if ((n & 1) == 0) u = mk(K_MUL16, A_EST2 + i, A_DT16, A_T, 1'b0);
        else u = mk(K_ADD, A_EST0 + i, A_T, A_EST0 + i, 1'b0);
      end else if (n < 20) begin
        k = n - 4; j = k >> 2; m = k & 3;
        case (m)
          0: u = mk(K_MUL, A_P + 8 + j, A_DT, A_T, 1'b0);
          1: u = mk(K_ADD, A_P + j, A_T, A_P + j, 1'b0);
          2: u = mk(K_MUL, A_P + 12 + j, A_DT, A_T, 1'b0);
          default: u = mk(K_ADD, A_P + 4 + j, A_T, A_P + 4 + j, 1'b0);
        endcase
      end else if (n < 36) begin
        k = n - 20; i = k >> 2; m = k & 3;
        case (m)
          0: u = mk(K_MUL, A_P + 4 * i + 2, A_DT, A_T, 1'b0);
          1: u = mk(K_ADD, A_P + 4 * i, A_T, A_P + 4 * i, 1'b0);
          2: u = mk(K_MUL, A_P + 4 * i + 3, A_DT, A_T, 1'b0);
          default: u = mk(K_ADD, A_P + 4 * i + 1, A_T, A_P + 4 * i + 1, 1'b0);
        endcase
      end else begin
        i = n - 36;
        u = mk(K_ADD, A_P + 5 * i, A_Q, A_P + 5 * i, i == 3);
      end
    end else if (n < UPD_BASE) begin
      k = n - INIT_BASE;
      if (k == 0) u = mk(K_ADD, A_MX, A_ZERO, A_EST0, 1'b0);
      else if (k == 1) u = mk(K_ADD, A_MY, A_ZERO, A_EST1, 1'b0);
      else if (k < 4) u = mk(K_ADD, A_ZERO, A_ZERO, A_EST0 + k, 1'b0);
      else begin
        k = k - 4;
        if (k == 0 || k == 5 || k == 10 || k == 15)
          u = mk(K_ADD, A_ONE, A_ZERO, A_P + k, k == 15);
        else u = mk(K_ADD, A_ZERO, A_ZERO, A_P + k, 1'b0);
      end
    end else begin
      k = n - UPD_BASE;
      if (k < 14) begin
        case (k)
          0:  u = mk(K_ADD, A_P + 0, A_R, A_S00, 1'b0);
          1:  u = mk(K_ADD, A_P + 1, A_ZERO, A_S01, 1'b0);
          2:  u = mk(K_ADD, A_P + 4, A_ZERO, A_S10, 1'b0);
          3:  u = mk(K_ADD, A_P + 5, A_R, A_S11, 1'b0);
          4:  u = mk(K_MUL, A_S00, A_S11, A_T, 1'b0);
          5:  u = mk(K_MUL, A_S01, A_S10, A_T2, 1'b0);
          6:  u = mk(K_SUB, A_T, A_T2, A_DET, 1'b0);
          7:  u = mk(K_CHKZ, A_DET, A_ZERO, A_ZERO, 1'b0);
          8:  u = mk(K_DIV, A_S11, A_DET, A_INV, 1'b0);
          9:  u = mk(K_SUB, A_ZERO, A_S01, A_T, 1'b0);
          10: u = mk(K_DIV, A_T, A_DET, A_INV + 1, 1'b0);
          11: u = mk(K_SUB, A_ZERO, A_S10, A_T, 1'b0);
          12: u = mk(K_DIV, A_T, A_DET, A_INV + 2, 1'b0);
          default: u = mk(K_DIV, A_S00, A_DET, A_INV + 3, 1'b0);
        endcase
      end else if (k < 46) begin
        g = (k - 14) >> 2; m = (k - 14) & 3; i = g >> 1; j = g & 1;
        case (m)
          0: u = mk(K_MUL, A_P + 4 * i, A_INV + j, A_T, 1'b0);
          1: u = mk(K_MUL, A_P + 4 * i + 1, A_INV + 2 + j, A_T2, 1'b0);
          2: u = mk(K_ADD, A_T, A_T2, A_K + g, 1'b0);
          default: u = mk(K_NOP, A_ZERO, A_ZERO, A_ZERO, 1'b0);
        endcase
      end else if (k < 50) begin
        case (k - 46)
          0: u = mk(K_ADD, A_EST0, A_ZERO, A_T, 1'b0);
          1: u = mk(K_SUB, A_MX, A_T, A_IN0, 1'b0);
          2: u = mk(K_ADD, A_EST1, A_ZERO, A_T, 1'b0);
          default: u = mk(K_SUB, A_MY, A_T, A_IN1, 1'b0);
        endcase
      end else if (k < 66) begin
        i = (k - 50) >> 2; m = (k - 50) & 3;
        case (m)
          0: u = mk(K_MUL, A_K + 2 * i, A_IN0, A_T, 1'b0);
          1: u = mk(K_MUL, A_K + 2 * i + 1, A_IN1, A_T2, 1'b0);
          2: u = mk(K_ADD, A_T, A_T2, A_T, 1'b0);
          default: u = mk(K_ADD, A_EST0 + i, A_T, A_EST0 + i, 1'b0);
        endcase
      end else if (k < 130) begin
        g = (k - 66) >> 2; m = (k - 66) & 3; i = g >> 2; j = g & 3;
        case (m)
          0: u = mk(K_MUL, A_K + 2 * i, A_P + j, A_T, 1'b0);
          1: u = mk(K_SUB, A_P + 4 * i + j, A_T, A_T2, 1'b0);
          2: u = mk(K_MUL, A_K + 2 * i + 1, A_P + 4 + j, A_T, 1'b0);
          default: begin
            // rows 0 and 1 are still read later: park them
            if (i < 2) u = mk(K_SUB, A_T2, A_T, A_NP + 4 * i + j, 1'b0);
            else u = mk(K_SUB, A_T2, A_T, A_P + 4 * i + j, 1'b0);
          end
        endcase
      end else if (k < 138) begin
        g = k - 130;
        u = mk(K_ADD, A_NP + g, A_ZERO, A_P + g, g == 7);
      end
    end
    return u;
  endfunction

endpackage

// File: rtl/core/kalman_tracker_2d_const_velocity.sv
// Top level of the 2-D constant-velocity Kalman tracker: stream ports,
// micro-program sequencer and state registers. Uses kct_pkg, kct_regfile, kct_alu.
//
// One item is taken at a time; s_axis_tready is high only while the sequencer is
// idle. Every item gives one beat on the master side. The work runs as a
// micro-program on one shared arithmetic unit and a 64-entry scratch memory;
// the four divides of the 2x2 inverse dominate a later update.
// Configuration writes are taken at any time and must only be issued while idle.
module kalman_tracker_2d_const_velocity
  import kct_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // time_step, meas_x, meas_y
  input  logic         s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // pos_x, pos_y, vel_x, vel_y
  output logic         m_axis_tuser,  // is_tracking
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  seq_state_e st_q, st_d;
  logic [7:0]  pc_q;
  logic [31:0] dt_q, mx_q, my_q, pn_q, mn_q;
  logic [31:0] est_q [4];
  logic        track_q, m_valid_q, m_user_q;
  logic [127:0] m_data_q;

  uop_t               uop;
  logic [63:0]        rd_a, rd_b;
  logic signed [63:0] opa, opb, alu_res;
  logic               alu_done, accept, start_go, chk_zero;
  logic [7:0]         start_pc;
  logic               mem_wen, est_wen, out_load, step_adv;
  alu_req_t           alu_req;

  assign uop = prog_rom(pc_q);

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (s_axis_tuser == OP_PREDICT) begin
      start_go = track_q && (s_axis_tdata[31:0] != 32'd0);
      start_pc = 8'(PRED_BASE);
    end else begin
      start_go = 1'b1;
      start_pc = track_q ? 8'(UPD_BASE) : 8'(INIT_BASE);
    end
  end

  // operand select: scratch memory or register operand
  always_comb begin
    opa = rd_a;
    if (uop.src_a[6]) begin
      case (int'(uop.src_a))
        A_EST0:  opa = {{32{est_q[0][31]}}, est_q[0]};
        A_EST1:  opa = {{32{est_q[1][31]}}, est_q[1]};
        A_EST2:  opa = {{32{est_q[2][31]}}, est_q[2]};
        A_EST3:  opa = {{32{est_q[3][31]}}, est_q[3]};
        A_MX:    opa = {{32{mx_q[31]}}, mx_q};
        A_MY:    opa = {{32{my_q[31]}}, my_q};
        A_ONE:   opa = {32'd1, 32'd0};
        default: opa = '0;
      endcase
    end
    opb = rd_b;
    if (uop.src_b[6]) begin
      case (int'(uop.src_b))
        A_DT16:  opb = {32'd0, dt_q};
        A_DT:    opb = {16'd0, dt_q, 16'd0};
        A_Q:     opb = {16'd0, pn_q, 16'd0};
        A_R:     opb = {16'd0, mn_q, 16'd0};
        default: opb = '0;
      endcase
    end
  end

  assign chk_zero = (opa == 64'sd0);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (accept) st_d = start_go ? ST_FETCH : ST_OUT;
      ST_FETCH: st_d = ST_EXEC;
      ST_EXEC: begin
        case (uop.kind)
          K_NOP:   st_d = uop.last ? ST_OUT : ST_FETCH;
          K_CHKZ:  st_d = (chk_zero || uop.last) ? ST_OUT : ST_FETCH;
          default: st_d = ST_WAIT;
        endcase
      end
      ST_WAIT:  if (alu_done) st_d = uop.last ? ST_OUT : ST_FETCH;
      ST_OUT:   if (!m_valid_q || m_axis_tready) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (st_q == ST_IDLE);
    alu_req.start = (st_q == ST_EXEC) && (uop.kind != K_NOP) && (uop.kind != K_CHKZ);
    alu_req.kind  = uop.kind;
    mem_wen  = (st_q == ST_WAIT) && alu_done && !uop.dst[6];
    est_wen  = (st_q == ST_WAIT) && alu_done && uop.dst[6] && (uop.dst[5:2] == 4'd0);
    step_adv = ((st_q == ST_WAIT) && alu_done) ||
               ((st_q == ST_EXEC) && (uop.kind == K_NOP || uop.kind == K_CHKZ));
    out_load = (st_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  end

  kct_regfile u_regfile (
    .clk_i       (clk_i),
    .wr_en_i     (mem_wen),
    .wr_addr_i   (uop.dst[5:0]),
    .wr_data_i   (alu_res),
    .rd_addr_a_i (uop.src_a[5:0]),
    .rd_addr_b_i (uop.src_b[5:0]),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  kct_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (opa),
    .b_i    (opb),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      track_q   <= 1'b0;
      m_valid_q <= 1'b0;
      pn_q      <= NOISE_RESET;
      mn_q      <= NOISE_RESET;
      est_q[0]  <= '0;
      est_q[1]  <= '0;
      est_q[2]  <= '0;
      est_q[3]  <= '0;
      pc_q      <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_PROCESS_NOISE:     pn_q <= cfg_data_i;
          CFG_MEASUREMENT_NOISE: mn_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        pc_q <= start_pc;
        if (s_axis_tuser != OP_PREDICT) track_q <= 1'b1;
      end else if (step_adv) begin
        pc_q <= pc_q + 8'd1;
      end
      if (est_wen) est_q[uop.dst[1:0]] <= sat32(alu_res);
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q <= s_axis_tdata[31:0];
      mx_q <= s_axis_tdata[63:32];
      my_q <= s_axis_tdata[95:64];
    end
    if (out_load) begin
      m_data_q <= {est_q[3], est_q[2], est_q[1], est_q[0]};
      m_user_q <= track_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// File: rtl/core/kct_regfile.sv
// Scratch memory of the tracker: covariance and temporaries, 64 x 64 bits.
// One write port, two registered read ports. Uses nothing else.
module kct_regfile (
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_addr_i,
  input  logic [63:0] wr_data_i,
  input  logic [5:0]  rd_addr_a_i,
  input  logic [5:0]  rd_addr_b_i,
  output logic [63:0] rd_data_a_o,
  output logic [63:0] rd_data_b_o
);

  logic [63:0] mem [64];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    rd_data_a_o <= mem[rd_addr_a_i];
    rd_data_b_o <= mem[rd_addr_b_i];
  end

endmodule

// File: rtl/core/kct_alu.sv
// Shared arithmetic unit: saturating add/subtract, multi-cycle Q-format
// multiply (32x32 partial products) and bit-serial divide. Uses kct_pkg.
module kct_alu
  import kct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alu_req_t           req_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  alu_state_e st_q, st_d;
  kind_e       kind_q;
  logic [6:0]  cnt_q;
  logic [63:0] x_q, y_q, pp_q, q_q, rem_q;
  logic [127:0] acc_q, dvd_q;
  logic        neg_q, ovf_q;
  logic signed [63:0] res_q;

  logic [63:0]        mag_a, mag_b, fin_mag;
  logic signed [64:0] sum;
  logic [63:0]        sum_sat;
  logic [2:0]         pcnt;
  logic [127:0]       pp_sh;
  logic [64:0]        remx;
  logic               fin_ovf;
  logic signed [63:0] fin_res;

  assign mag_a = a_i[63] ? 64'(-a_i) : a_i;
  assign mag_b = b_i[63] ? 64'(-b_i) : b_i;

  always_comb begin
    if (req_i.kind == K_SUB) sum = {a_i[63], a_i} - {b_i[63], b_i};
    else sum = {a_i[63], a_i} + {b_i[63], b_i};
    if (sum[64] != sum[63]) sum_sat = sum[64] ? S64_MIN : S64_MAX;
    else sum_sat = sum[63:0];
  end

  // align the previous partial product
  always_comb begin
    pcnt = cnt_q[2:0] - 3'd1;
    case (pcnt)
      3'd0:    pp_sh = {64'b0, pp_q};
      3'd3:    pp_sh = {pp_q, 64'b0};
      default: pp_sh = {32'b0, pp_q, 32'b0};
    endcase
  end

  assign remx = {rem_q, dvd_q[127]};

  always_comb begin
    if (kind_q == K_DIV) begin
      fin_mag = q_q;
      fin_ovf = ovf_q;
    end else if (kind_q == K_MUL16) begin
      fin_mag = acc_q[79:16];
      fin_ovf = |acc_q[127:80];
    end else begin
      fin_mag = acc_q[95:32];
      fin_ovf = |acc_q[127:96];
    end
    if (fin_ovf) fin_res = neg_q ? S64_MIN : S64_MAX;
    else if (neg_q) fin_res = fin_mag[63] ? S64_MIN : 64'(-fin_mag);
    else fin_res = fin_mag[63] ? S64_MAX : fin_mag;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      AS_IDLE: begin
        if (req_i.start) begin
          case (req_i.kind)
            K_MUL, K_MUL16: st_d = AS_MUL;
            K_DIV:          st_d = AS_DIV;
            default:        st_d = AS_DONE;
          endcase
        end
      end
      AS_MUL:  if (cnt_q == 7'd4) st_d = AS_FIN;
      AS_DIV:  if (cnt_q == 7'd127) st_d = AS_FIN;
      AS_FIN:  st_d = AS_DONE;
      AS_DONE: st_d = AS_IDLE;
      default: st_d = AS_IDLE;
    endcase
  end

  always_comb begin
    done_o = (st_q == AS_DONE);
    res_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= AS_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      AS_IDLE: begin
        if (req_i.start) begin
          kind_q <= req_i.kind;
          neg_q  <= a_i[63] ^ b_i[63];
          x_q    <= mag_a;
          y_q    <= mag_b;
          cnt_q  <= '0;
          acc_q  <= '0;
          ovf_q  <= 1'b0;
          q_q    <= '0;
          rem_q  <= '0;
          dvd_q  <= {32'b0, mag_a, 32'b0};
          res_q  <= sum_sat;
        end
      end
      AS_MUL: begin
        if (cnt_q[2:0] != 3'd4)
          pp_q <= (cnt_q[1] ? x_q[63:32] : x_q[31:0]) * (cnt_q[0] ? y_q[63:32] : y_q[31:0]);
        if (cnt_q[2:0] != 3'd0) acc_q <= acc_q + pp_sh;
        cnt_q <= cnt_q + 7'd1;
      end
      AS_DIV: begin
        dvd_q <= {dvd_q[126:0], 1'b0};
        if (q_q[63]) ovf_q <= 1'b1;
        if (remx >= {1'b0, y_q}) begin
          rem_q <= 64'(remx - {1'b0, y_q});
          q_q   <= {q_q[62:0], 1'b1};
        end else begin
          rem_q <= remx[63:0];
          q_q   <= {q_q[62:0], 1'b0};
        end
        cnt_q <= cnt_q + 7'd1;
      end
      AS_FIN:  res_q <= fin_res;
      default: ;
    endcase
  end

endmodule
